// ----- rtl/mqs_pkg.sv -----
`default_nettype none
package mqs_pkg;

    // Statistics saturate at this many values.
    localparam int unsigned MAX_ITEMS    = 16777216;
    // Number of CORDIC rotations for the arc cosine (12 to 32).
    localparam int unsigned CORDIC_STEPS = 24;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_FACE   = 2'd0;
    localparam t_mode MODE_CELL   = 2'd1;
    localparam t_mode MODE_REPORT = 2'd2;

    // Statistic slots, which are also the record codes of the report.
    typedef logic [2:0] t_rec;
    localparam t_rec REC_AREA    = 3'd0;
    localparam t_rec REC_SIZE    = 3'd1;
    localparam t_rec REC_LENGTH  = 3'd2;
    localparam t_rec REC_QUALITY = 3'd3;
    localparam t_rec REC_ANGLE   = 3'd4;
    localparam t_rec REC_RATIO   = 3'd5;
    localparam t_rec REC_TALLY   = 3'd6;

    typedef logic signed [47:0] t_q48;
    localparam t_q48 MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam t_q48 MIN48 = 48'sh8000_0000_0000;

    // CORDIC width: vector 1.0 at 2^30, angle in Q8.24 degrees.
    typedef logic signed [33:0] t_cw;
    localparam t_cw DEG90_Q24  = 34'sd1509949440;
    localparam t_cw DEG180_Q24 = 34'sd3019898880;

    function automatic t_cw atan_deg(input logic [4:0] idx);
        t_cw v;
        unique case (idx)
            5'd0:  v = 34'sd754974720;
            5'd1:  v = 34'sd445687602;
            5'd2:  v = 34'sd235489088;
            5'd3:  v = 34'sd119537938;
            5'd4:  v = 34'sd60000934;
            5'd5:  v = 34'sd30029717;
            5'd6:  v = 34'sd15018523;
            5'd7:  v = 34'sd7509720;
            5'd8:  v = 34'sd3754917;
            5'd9:  v = 34'sd1877466;
            5'd10: v = 34'sd938734;
            5'd11: v = 34'sd469367;
            5'd12: v = 34'sd234683;
            5'd13: v = 34'sd117342;
            5'd14: v = 34'sd58671;
            5'd15: v = 34'sd29335;
            5'd16: v = 34'sd14668;
            5'd17: v = 34'sd7334;
            5'd18: v = 34'sd3667;
            5'd19: v = 34'sd1833;
            5'd20: v = 34'sd917;
            5'd21: v = 34'sd458;
            5'd22: v = 34'sd229;
            5'd23: v = 34'sd115;
            5'd24: v = 34'sd57;
            5'd25: v = 34'sd29;
            5'd26: v = 34'sd14;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            5'd31: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mqs_sqrt.sv -----
`default_nettype none
// Integer square root of a 64-bit value, one result bit per cycle.
module mqs_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_n,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_n;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] w_sum;
    logic        w_ge;

    assign w_sum = r_r + r_bit;
    assign w_ge  = (r_n >= w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (w_ge) begin
                r_n <= r_n - w_sum;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule
`default_nettype wire

// ----- rtl/mqs_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. The remainder starts at
// i_rem and the bits of i_num are shifted in from the top.
module mqs_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_rem,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    input  wire logic [6:0]  i_steps,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_q;
    logic [64:0] w_t;
    logic [64:0] w_diff;
    logic        w_ge;

    assign w_t    = {r_rem, r_num[63]};
    assign w_ge   = (w_t >= {1'b0, r_den});
    assign w_diff = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[63:0] : w_t[63:0];
            r_num <= r_num << 1;
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ----- rtl/mqs_cordic.sv -----
`default_nettype none
// Vectoring CORDIC: drives y to zero and accumulates the angle in degrees.
module mqs_cordic (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire mqs_pkg::t_cw  i_x,
    input  wire mqs_pkg::t_cw  i_y,
    input  wire mqs_pkg::t_cw  i_z,
    output logic               o_done,
    output mqs_pkg::t_cw       o_z
);

    localparam logic [4:0] LAST_STEP = 5'(mqs_pkg::CORDIC_STEPS - 1);

    logic         r_busy;
    logic         r_done;
    logic [4:0]   r_i;
    mqs_pkg::t_cw r_x;
    mqs_pkg::t_cw r_y;
    mqs_pkg::t_cw r_z;
    mqs_pkg::t_cw w_xs;
    mqs_pkg::t_cw w_ys;
    mqs_pkg::t_cw w_at;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = mqs_pkg::atan_deg(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            if (!r_y[33]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule
`default_nettype wire

// ----- rtl/mesh_quality_statistics_unit.sv -----
`default_nettype none
// Mesh quality statistics unit.
// The input channel (i_valid / o_ready) takes one transaction per mesh item:
// a face (i_mode face), a cell (i_mode cell) or a report request. o_ready is
// high only while the sequencer is idle, so one item is worked on at a time.
// A boundary face needs no sequencer pass. A cell's time is set by one
// pass of the bit-serial square root. An internal face runs the shared
// square root up to four times (centre distance, sine term, two cell
// sizes), the shared divider up to twice (cosine, size ratio) and the
// CORDIC at most once. A report works out each mean with the shared
// divider and sends seven transactions on the output channel
// (o_valid / i_ready), the last with o_last set; all statistics then clear.
// The output register holds a record until the receiver takes it; while the
// receiver stalls, the report sequence waits and no new item is accepted
// until the last record of the report has been loaded.
// Synchronous reset clears every statistic, tally and id counter and leaves
// both channels empty.
module mesh_quality_statistics_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic               i_is_boundary,
    input  wire logic signed [31:0] i_owner_x,
    input  wire logic signed [31:0] i_owner_y,
    input  wire logic signed [31:0] i_neighbour_x,
    input  wire logic signed [31:0] i_neighbour_y,
    input  wire logic signed [31:0] i_normal_x,
    input  wire logic signed [31:0] i_normal_y,
    input  wire logic [31:0]        i_edge_length,
    input  wire logic [31:0]        i_first_area,
    input  wire logic [31:0]        i_second_area,
    input  wire logic signed [31:0] i_quality,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_record,
    output logic signed [47:0]      o_minimum,
    output logic signed [47:0]      o_maximum,
    output logic signed [47:0]      o_mean,
    output logic [24:0]             o_value_count,
    output logic [23:0]             o_extreme_id,
    output logic                    o_last
);

    // Sequencer states, one-hot.
    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_MXX   = 25'h0000002,
        S_MYY   = 25'h0000004,
        S_HSUM  = 25'h0000008,
        S_HSQ   = 25'h0000010,
        S_DOT   = 25'h0000020,
        S_HWAIT = 25'h0000040,
        S_DEN   = 25'h0000080,
        S_CHK   = 25'h0000100,
        S_CDIV  = 25'h0000200,
        S_CSQ   = 25'h0000400,
        S_YSQ   = 25'h0000800,
        S_YWAIT = 25'h0001000,
        S_COR   = 25'h0002000,
        S_ANGC  = 25'h0004000,
        S_S1    = 25'h0008000,
        S_S2    = 25'h0010000,
        S_RDIV  = 25'h0020000,
        S_RATC  = 25'h0040000,
        S_CS    = 25'h0080000,
        S_CQ    = 25'h0100000,
        S_RM    = 25'h0200000,
        S_RW    = 25'h0400000,
        S_RE    = 25'h0800000,
        S_RT    = 25'h1000000
    } t_state;

    localparam logic [24:0] SAT_ITEMS = 25'(mqs_pkg::MAX_ITEMS);

    t_state r_state;
    t_state n_state;

    // Latched item fields.
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic signed [31:0] r_ax;
    logic signed [31:0] r_ay;
    logic [31:0]        r_len;
    logic [31:0]        r_a1;
    logic [31:0]        r_a2;
    logic signed [31:0] r_q;
    logic [23:0]        r_id;

    // Datapath registers.
    logic signed [65:0] r_prod;
    logic [63:0]        r_acc;
    logic signed [63:0] r_dot;
    logic [31:0]        r_h;
    logic signed [31:0] r_c;
    logic [47:0]        r_val;
    logic [23:0]        r_s1;
    logic signed [47:0] r_mean;
    logic               r_neg;
    logic [2:0]         r_rk;

    // Statistics.
    mqs_pkg::t_q48 r_smin [6];
    mqs_pkg::t_q48 r_smax [6];
    logic signed [63:0] r_ssum [6];
    logic [24:0]   r_scnt [6];
    logic [23:0]   r_face_cnt;
    logic [23:0]   r_cell_cnt;
    logic [24:0]   r_int_faces;
    logic [24:0]   r_bnd_faces;
    logic [23:0]   r_ang_id;
    logic [23:0]   r_rat_id;
    logic [23:0]   r_qual_id;
    logic [63:0]   r_total;

    // Output register.
    logic          r_out_valid;
    logic [2:0]    r_out_rec;
    mqs_pkg::t_q48 r_out_min;
    mqs_pkg::t_q48 r_out_max;
    mqs_pkg::t_q48 r_out_mean;
    logic [24:0]   r_out_cnt;
    logic [23:0]   r_out_id;
    logic          r_out_last;

    logic w_acc_in;
    logic w_out_free;
    logic w_clear;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc_in   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_clear    = (r_state == S_RT) && w_out_free;

    // Centre displacement, both components halved toward zero once when either
    // lies outside the open range -2^31 to 2^31 (it never needs a second halving).
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic signed [32:0] w_hx;
    logic signed [32:0] w_hy;
    logic               w_big;

    assign w_dx  = {i_neighbour_x[31], i_neighbour_x} - {i_owner_x[31], i_owner_x};
    assign w_dy  = {i_neighbour_y[31], i_neighbour_y} - {i_owner_y[31], i_owner_y};
    assign w_big = (w_dx[32] != w_dx[31]) || (w_dx[32:31] == 2'b11 && w_dx[30:0] == '0)
                || (w_dy[32] != w_dy[31]) || (w_dy[32:31] == 2'b11 && w_dy[30:0] == '0);
    assign w_hx  = w_dx[32] ? ((w_dx + 33'sd1) >>> 1) : (w_dx >>> 1);
    assign w_hy  = w_dy[32] ? ((w_dy + 33'sd1) >>> 1) : (w_dy >>> 1);

    // Shared multiplier with its operand selection.
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MXX: begin
                w_ma = {r_dx[31], r_dx};
                w_mb = {r_dx[31], r_dx};
            end
            S_MYY: begin
                w_ma = {r_dy[31], r_dy};
                w_mb = {r_dy[31], r_dy};
            end
            S_HSUM: begin
                w_ma = {r_dx[31], r_dx};
                w_mb = {r_ax[31], r_ax};
            end
            S_HSQ: begin
                w_ma = {r_dy[31], r_dy};
                w_mb = {r_ay[31], r_ay};
            end
            S_DEN: begin
                w_ma = {1'b0, r_h};
                w_mb = {1'b0, r_len};
            end
            S_CSQ: begin
                w_ma = {r_c[31], r_c};
                w_mb = {r_c[31], r_c};
            end
            default: ;
        endcase
    end

    // Square root unit.
    logic        w_sq_start;
    logic [63:0] w_sq_n;
    logic        w_sq_done;
    logic [31:0] w_root;

    // Divider unit.
    logic        w_dv_start;
    logic [63:0] w_dv_rem;
    logic [63:0] w_dv_num;
    logic [63:0] w_dv_den;
    logic [6:0]  w_dv_steps;
    logic        w_dv_done;
    logic [63:0] w_quot;

    // CORDIC unit.
    logic         w_cr_start;
    mqs_pkg::t_cw w_cr_x;
    mqs_pkg::t_cw w_cr_y;
    mqs_pkg::t_cw w_cr_z;
    logic         w_cr_done;
    mqs_pkg::t_cw w_cr_zo;

    // Statistic access: one index for both the update and the report read.
    logic          w_upd;
    logic [2:0]    w_uk;
    mqs_pkg::t_q48 w_uv;
    logic [2:0]    w_rdk;
    mqs_pkg::t_q48 w_cmin;
    mqs_pkg::t_q48 w_cmax;
    logic signed [63:0] w_csum;
    logic [24:0]   w_ccnt;
    logic          w_added;
    logic [63:0]   w_abs_sum;

    assign w_rdk     = (r_state == S_RM || r_state == S_RE) ? r_rk : w_uk;
    assign w_cmin    = r_smin[w_rdk];
    assign w_cmax    = r_smax[w_rdk];
    assign w_csum    = r_ssum[w_rdk];
    assign w_ccnt    = r_scnt[w_rdk];
    assign w_added   = (w_ccnt < SAT_ITEMS);
    assign w_abs_sum = w_csum[63] ? 64'(-w_csum) : 64'(w_csum);

    // Cosine magnitude and the cell size pair.
    logic [63:0] w_mag;
    logic [23:0] w_lg;
    logic [23:0] w_sm;

    assign w_mag = r_dot[63] ? 64'(-r_dot) : 64'(r_dot);
    assign w_lg  = (r_s1 > w_root[23:0]) ? r_s1 : w_root[23:0];
    assign w_sm  = (r_s1 > w_root[23:0]) ? w_root[23:0] : r_s1;

    // Angle: clamp to [0, 180] degrees, then round Q8.24 to Q16.16.
    mqs_pkg::t_cw w_zc;
    mqs_pkg::t_cw w_zr;

    always_comb begin
        if (w_cr_zo[33]) begin
            w_zc = '0;
        end else if (w_cr_zo > mqs_pkg::DEG180_Q24) begin
            w_zc = mqs_pkg::DEG180_Q24;
        end else begin
            w_zc = w_cr_zo;
        end
    end
    assign w_zr = (w_zc + 34'sd128) >>> 8;

    // Unit requests and statistic updates per state.
    always_comb begin
        w_sq_start = 1'b0;
        w_sq_n     = '0;
        w_dv_start = 1'b0;
        w_dv_rem   = '0;
        w_dv_num   = '0;
        w_dv_den   = '0;
        w_dv_steps = 7'd64;
        w_cr_start = 1'b0;
        w_cr_x     = '0;
        w_cr_y     = '0;
        w_cr_z     = '0;
        w_upd      = 1'b0;
        w_uk       = mqs_pkg::REC_AREA;
        w_uv       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in && i_mode == mqs_pkg::MODE_FACE) begin
                    w_upd = 1'b1;
                    w_uk  = mqs_pkg::REC_LENGTH;
                    w_uv  = {16'h0, i_edge_length};
                end else if (w_acc_in && i_mode == mqs_pkg::MODE_CELL) begin
                    w_upd      = 1'b1;
                    w_uk       = mqs_pkg::REC_AREA;
                    w_uv       = {16'h0, i_first_area};
                    w_sq_start = 1'b1;
                    w_sq_n     = {16'h0, i_first_area, 16'h0};
                end
            end
            S_HSQ: begin
                w_sq_start = 1'b1;
                w_sq_n     = r_acc;
            end
            S_CHK: begin
                w_dv_rem   = w_mag;
                w_dv_den   = r_prod[63:0];
                w_dv_steps = 7'd30;
                w_dv_start = (r_prod[63:0] != '0) && (w_mag < r_prod[63:0]);
            end
            S_YSQ: begin
                w_sq_start = 1'b1;
                w_sq_n     = 64'h1000_0000_0000_0000 - r_prod[63:0];
            end
            S_YWAIT: begin
                w_cr_start = w_sq_done;
                if (r_c[31]) begin
                    w_cr_x = {2'b00, w_root};
                    w_cr_y = -{{2{r_c[31]}}, r_c};
                    w_cr_z = mqs_pkg::DEG90_Q24;
                end else begin
                    w_cr_x = {{2{r_c[31]}}, r_c};
                    w_cr_y = {2'b00, w_root};
                end
            end
            S_ANGC: begin
                w_upd      = 1'b1;
                w_uk       = mqs_pkg::REC_ANGLE;
                w_uv       = r_val;
                w_sq_start = 1'b1;
                w_sq_n     = {16'h0, r_a1, 16'h0};
            end
            S_S1: begin
                w_sq_start = w_sq_done;
                w_sq_n     = {16'h0, r_a2, 16'h0};
            end
            S_S2: begin
                w_dv_num   = {w_lg, 40'h0};
                w_dv_den   = {40'h0, w_sm};
                w_dv_steps = 7'd40;
                w_dv_start = w_sq_done && (w_sm != '0);
            end
            S_RATC: begin
                w_upd = 1'b1;
                w_uk  = mqs_pkg::REC_RATIO;
                w_uv  = r_val;
            end
            S_CS: begin
                w_upd = w_sq_done;
                w_uk  = mqs_pkg::REC_SIZE;
                w_uv  = {16'h0, w_root};
            end
            S_CQ: begin
                w_upd = 1'b1;
                w_uk  = mqs_pkg::REC_QUALITY;
                w_uv  = {{16{r_q[31]}}, r_q};
            end
            S_RM: begin
                w_dv_num   = w_abs_sum;
                w_dv_den   = {39'h0, w_ccnt};
                w_dv_steps = 7'd64;
                w_dv_start = (w_ccnt != '0);
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    unique case (i_mode)
                        mqs_pkg::MODE_FACE:   n_state = i_is_boundary ? S_IDLE : S_MXX;
                        mqs_pkg::MODE_CELL:   n_state = S_CS;
                        mqs_pkg::MODE_REPORT: n_state = S_RM;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_MXX:   n_state = S_MYY;
            S_MYY:   n_state = S_HSUM;
            S_HSUM:  n_state = S_HSQ;
            S_HSQ:   n_state = S_DOT;
            S_DOT:   n_state = S_HWAIT;
            S_HWAIT: n_state = w_sq_done ? S_DEN : S_HWAIT;
            S_DEN:   n_state = S_CHK;
            S_CHK: begin
                if (r_prod[63:0] == '0) begin
                    n_state = S_ANGC;
                end else if (w_mag >= r_prod[63:0]) begin
                    n_state = S_CSQ;
                end else begin
                    n_state = S_CDIV;
                end
            end
            S_CDIV:  n_state = w_dv_done ? S_CSQ : S_CDIV;
            S_CSQ:   n_state = S_YSQ;
            S_YSQ:   n_state = S_YWAIT;
            S_YWAIT: n_state = w_sq_done ? S_COR : S_YWAIT;
            S_COR:   n_state = w_cr_done ? S_ANGC : S_COR;
            S_ANGC:  n_state = S_S1;
            S_S1:    n_state = w_sq_done ? S_S2 : S_S1;
            S_S2: begin
                if (w_sq_done) begin
                    n_state = (w_sm == '0) ? S_RATC : S_RDIV;
                end
            end
            S_RDIV:  n_state = w_dv_done ? S_RATC : S_RDIV;
            S_RATC:  n_state = S_IDLE;
            S_CS:    n_state = w_sq_done ? S_CQ : S_CS;
            S_CQ:    n_state = S_IDLE;
            S_RM:    n_state = (w_ccnt == '0) ? S_RE : S_RW;
            S_RW:    n_state = w_dv_done ? S_RE : S_RW;
            S_RE: begin
                if (w_out_free) begin
                    n_state = (r_rk == mqs_pkg::REC_RATIO) ? S_RT : S_RM;
                end
            end
            S_RT:    n_state = w_out_free ? S_IDLE : S_RT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    r_dx  <= w_big ? w_hx[31:0] : w_dx[31:0];
                    r_dy  <= w_big ? w_hy[31:0] : w_dy[31:0];
                    r_ax  <= i_normal_x;
                    r_ay  <= i_normal_y;
                    r_len <= i_edge_length;
                    r_a1  <= i_first_area;
                    r_a2  <= i_second_area;
                    r_q   <= i_quality;
                    r_id  <= (i_mode == mqs_pkg::MODE_CELL) ? r_cell_cnt : r_face_cnt;
                    r_rk  <= mqs_pkg::REC_AREA;
                end
            end
            S_MYY:  r_acc <= r_prod[63:0];
            S_HSUM: r_acc <= r_acc + r_prod[63:0];
            S_HSQ:  r_dot <= r_prod[63:0];
            S_DOT:  r_dot <= r_dot + r_prod[63:0];
            S_HWAIT: begin
                if (w_sq_done) begin
                    r_h <= w_root;
                end
            end
            S_CHK: begin
                if (r_prod[63:0] == '0) begin
                    r_val <= '0;
                end else begin
                    r_c <= r_dot[63] ? -32'sh4000_0000 : 32'sh4000_0000;
                end
            end
            S_CDIV: begin
                if (w_dv_done) begin
                    r_c <= r_dot[63] ? -{1'b0, w_quot[30:0]} : {1'b0, w_quot[30:0]};
                end
            end
            S_COR: begin
                if (w_cr_done) begin
                    r_val <= {24'h0, w_zr[23:0]};
                end
            end
            S_S1: begin
                if (w_sq_done) begin
                    r_s1 <= w_root[23:0];
                end
            end
            S_S2: begin
                if (w_sq_done && w_sm == '0) begin
                    r_val <= 48'h0000_FFFF_FFFF;
                end
            end
            S_RDIV: begin
                if (w_dv_done) begin
                    r_val <= (w_quot[39:32] != '0) ? 48'h0000_FFFF_FFFF
                                                   : {16'h0, w_quot[31:0]};
                end
            end
            S_RM: begin
                r_neg  <= w_csum[63];
                r_mean <= '0;
            end
            S_RW: begin
                if (w_dv_done) begin
                    r_mean <= r_neg ? -$signed(w_quot[47:0]) : $signed(w_quot[47:0]);
                end
            end
            S_RE: begin
                if (w_out_free) begin
                    r_rk <= r_rk + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // Statistics store: one update per cycle at most.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int k = 0; k < 6; k++) begin
                r_smin[k] <= mqs_pkg::MAX48;
                r_smax[k] <= mqs_pkg::MIN48;
                r_ssum[k] <= '0;
                r_scnt[k] <= '0;
            end
            r_ang_id  <= '0;
            r_rat_id  <= '0;
            r_qual_id <= '0;
        end else if (w_upd && w_added) begin
            if (w_uv < w_cmin) begin
                r_smin[w_uk] <= w_uv;
            end
            if (w_uv > w_cmax) begin
                r_smax[w_uk] <= w_uv;
            end
            r_ssum[w_uk] <= w_csum + {{16{w_uv[47]}}, w_uv};
            r_scnt[w_uk] <= w_ccnt + 25'd1;
            // Strict compares keep the first id on ties.
            if (w_uk == mqs_pkg::REC_QUALITY && w_uv < w_cmin) begin
                r_qual_id <= r_id;
            end
            if (w_uk == mqs_pkg::REC_ANGLE && w_uv > w_cmax) begin
                r_ang_id <= r_id;
            end
            if (w_uk == mqs_pkg::REC_RATIO && w_uv > w_cmax) begin
                r_rat_id <= r_id;
            end
        end
    end

    // Item counters and face tallies.
    logic [64:0] w_tsum;
    assign w_tsum = {1'b0, r_total} + {33'h0, i_first_area};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_face_cnt  <= '0;
            r_cell_cnt  <= '0;
            r_int_faces <= '0;
            r_bnd_faces <= '0;
            r_total     <= '0;
        end else if (w_acc_in) begin
            if (i_mode == mqs_pkg::MODE_FACE) begin
                r_face_cnt <= r_face_cnt + 24'd1;
                if (i_is_boundary) begin
                    if (r_bnd_faces < SAT_ITEMS) begin
                        r_bnd_faces <= r_bnd_faces + 25'd1;
                    end
                end else if (r_int_faces < SAT_ITEMS) begin
                    r_int_faces <= r_int_faces + 25'd1;
                end
            end else if (i_mode == mqs_pkg::MODE_CELL) begin
                r_cell_cnt <= r_cell_cnt + 24'd1;
                r_total    <= w_tsum[64] ? '1 : w_tsum[63:0];
            end
        end
    end

    // Output register.
    mqs_pkg::t_q48 w_ta;
    logic [23:0]   w_rec_id;

    assign w_ta = (r_total[63:47] != '0) ? mqs_pkg::MAX48 : r_total[47:0];

    always_comb begin
        unique case (r_rk)
            mqs_pkg::REC_QUALITY: w_rec_id = r_qual_id;
            mqs_pkg::REC_ANGLE:   w_rec_id = r_ang_id;
            mqs_pkg::REC_RATIO:   w_rec_id = r_rat_id;
            default:              w_rec_id = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RE || r_state == S_RT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RE && w_out_free) begin
            r_out_rec  <= r_rk;
            r_out_min  <= (w_ccnt == '0) ? '0 : w_cmin;
            r_out_max  <= (w_ccnt == '0) ? '0 : w_cmax;
            r_out_mean <= r_mean;
            r_out_cnt  <= w_ccnt;
            r_out_id   <= w_rec_id;
            r_out_last <= 1'b0;
        end else if (r_state == S_RT && w_out_free) begin
            r_out_rec  <= mqs_pkg::REC_TALLY;
            r_out_min  <= w_ta;
            r_out_max  <= w_ta;
            r_out_mean <= w_ta;
            r_out_cnt  <= r_bnd_faces;
            r_out_id   <= r_int_faces[24] ? 24'hFF_FFFF : r_int_faces[23:0];
            r_out_last <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_record      = r_out_rec;
    assign o_minimum     = r_out_min;
    assign o_maximum     = r_out_max;
    assign o_mean        = r_out_mean;
    assign o_value_count = r_out_cnt;
    assign o_extreme_id  = r_out_id;
    assign o_last        = r_out_last;

    mqs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_n     (w_sq_n),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    mqs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_rem   (w_dv_rem),
        .i_num   (w_dv_num),
        .i_den   (w_dv_den),
        .i_steps (w_dv_steps),
        .o_done  (w_dv_done),
        .o_quot  (w_quot)
    );

    mqs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cr_start),
        .i_x     (w_cr_x),
        .i_y     (w_cr_y),
        .i_z     (w_cr_z),
        .o_done  (w_cr_done),
        .o_z     (w_cr_zo)
    );

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
// Mesh quality statistics testbench.
// A directed table of stimulus runs first, then a receiver hold-off and random
// face, cell, report and unused-mode transactions. Every accepted input
// transaction goes through a local statistics predictor, and every report
// pushes seven expected records onto a queue. Each output transaction is
// compared field by field with the oldest expected record. Inputs are driven
// at the falling clock edge and outputs are sampled at the rising edge.
module testbench;
    import mqs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 120;
    localparam int N_DIRECTED     = 22;

    typedef struct packed {
        logic [2:0]         rec;
        logic signed [47:0] mn;
        logic signed [47:0] mx;
        logic signed [47:0] mean;
        logic [24:0]        cnt;
        logic [23:0]        id;
        logic               last;
    } t_record;

    typedef struct {
        logic [1:0]         mode;
        logic               bnd;
        logic signed [31:0] ox, oy, nx, ny, ax, ay;
        logic [31:0]        len, a1, a2;
        logic signed [31:0] q;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_mode = MODE_FACE;
    logic i_is_boundary = 1'b0;
    logic signed [31:0] i_owner_x = '0, i_owner_y = '0;
    logic signed [31:0] i_neighbour_x = '0, i_neighbour_y = '0;
    logic signed [31:0] i_normal_x = '0, i_normal_y = '0;
    logic [31:0] i_edge_length = '0, i_first_area = '0, i_second_area = '0;
    logic signed [31:0] i_quality = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [2:0] o_record;
    logic signed [47:0] o_minimum, o_maximum, o_mean;
    logic [24:0] o_value_count;
    logic [23:0] o_extreme_id;
    logic o_last;

    mesh_quality_statistics_unit DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: one slot per statistic, plus tallies and ids.
    longint       st_min[6];
    longint       st_max[6];
    longint       st_sum[6];
    int unsigned  st_cnt[6];
    int unsigned  face_id, cell_id, n_internal, n_boundary;
    int unsigned  angle_id, ratio_id, quality_id;
    longint unsigned area_total;

    t_record report_queue[$];
    int      n_errors = 0;
    int      n_mismatch = 0;
    bit      stim_done = 1'b0;
    bit      hold_off = 1'b0;
    int      idle_cycles = 0;

    function automatic void clear_stats();
        for (int k = 0; k < 6; k++) begin
            st_min[k] = MAX48;
            st_max[k] = MIN48;
            st_sum[k] = 0;
            st_cnt[k] = 0;
        end
        face_id = 0; cell_id = 0; n_internal = 0; n_boundary = 0;
        angle_id = 0; ratio_id = 0; quality_id = 0;
        area_total = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit add_value(int k, longint v);
        if (st_cnt[k] >= MAX_ITEMS) return 1'b0;
        if (v < st_min[k]) st_min[k] = v;
        if (v > st_max[k]) st_max[k] = v;
        st_sum[k] += v;
        st_cnt[k]++;
        return 1'b1;
    endfunction

    // Non-orthogonality angle in Q16.16 degrees.
    function automatic longint face_angle(longint dx, longint dy, longint ax, longint ay,
                                          longint unsigned len);
        longint unsigned h, den, mag, r, q;
        longint dot, c, x, y, z, t, xs, ys;
        bit neg;
        while (dx >= 64'sh8000_0000 || dx <= -64'sh8000_0000 ||
               dy >= 64'sh8000_0000 || dy <= -64'sh8000_0000) begin
            dx = dx / 2;
            dy = dy / 2;
        end
        h = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        den = h * len;
        if (den == 0) return 0;
        dot = dx * ax + dy * ay;
        neg = dot < 0;
        mag = neg ? -dot : dot;
        if (mag >= den) begin
            c = 64'sh4000_0000;
        end else begin
            r = mag;
            q = 0;
            for (int i = 0; i < 30; i++) begin
                q <<= 1;
                if (r >= den - r) begin
                    r = r - (den - r);
                    q |= 1;
                end else begin
                    r <<= 1;
                end
            end
            c = q;
        end
        if (neg) c = -c;
        x = c;
        y = int_sqrt((64'd1 << 60) - longint'(c * c));
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 64'sd90 <<< 24;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_deg(5'(i)));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_deg(5'(i)));
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd180 <<< 24)) z = 64'sd180 <<< 24;
        return (z + 128) >>> 8;
    endfunction

    function automatic t_record make_record(int k, longint mn, longint mx, longint mean,
                                            int unsigned cnt, int unsigned id, bit last);
        t_record r;
        r.rec = 3'(k); r.mn = mn[47:0]; r.mx = mx[47:0]; r.mean = mean[47:0];
        r.cnt = cnt[24:0]; r.id = id[23:0]; r.last = last;
        return r;
    endfunction

    // Updates the statistics for one accepted transaction and queues any
    // report records it causes.
    function automatic void predict_item(t_item it);
        int unsigned id;
        longint ang, v;
        longint unsigned s1, s2, lg, sm, ratio;
        bit bigger;
        case (it.mode)
            MODE_FACE: begin
                id = face_id;
                face_id = (face_id + 1) & 24'hFF_FFFF;
                void'(add_value(REC_LENGTH, longint'(it.len)));
                if (it.bnd) begin
                    if (n_boundary < MAX_ITEMS) n_boundary++;
                end else begin
                    if (n_internal < MAX_ITEMS) n_internal++;
                    ang = face_angle(longint'(it.nx) - longint'(it.ox),
                                     longint'(it.ny) - longint'(it.oy),
                                     longint'(it.ax), longint'(it.ay), it.len);
                    bigger = ang > st_max[REC_ANGLE];
                    if (add_value(REC_ANGLE, ang) && bigger) angle_id = id;
                    s1 = int_sqrt(longint'(it.a1) << 16);
                    s2 = int_sqrt(longint'(it.a2) << 16);
                    lg = s1 > s2 ? s1 : s2;
                    sm = s1 > s2 ? s2 : s1;
                    ratio = 64'hFFFF_FFFF;
                    if (sm != 0 && ((lg << 16) / sm) < ratio) ratio = (lg << 16) / sm;
                    bigger = longint'(ratio) > st_max[REC_RATIO];
                    if (add_value(REC_RATIO, ratio) && bigger) ratio_id = id;
                end
            end
            MODE_CELL: begin
                id = cell_id;
                cell_id = (cell_id + 1) & 24'hFF_FFFF;
                void'(add_value(REC_AREA, longint'(it.a1)));
                void'(add_value(REC_SIZE, int_sqrt(longint'(it.a1) << 16)));
                area_total = (area_total > ~64'd0 - it.a1) ? ~64'd0 : area_total + it.a1;
                v = it.q;
                bigger = v < st_min[REC_QUALITY];
                if (add_value(REC_QUALITY, v) && bigger) quality_id = id;
            end
            MODE_REPORT: begin
                for (int k = 0; k < 6; k++) begin
                    id = k == REC_QUALITY ? quality_id : k == REC_ANGLE ? angle_id :
                         k == REC_RATIO ? ratio_id : 0;
                    if (st_cnt[k] == 0)
                        report_queue.push_back(make_record(k, 0, 0, 0, 0, id, 1'b0));
                    else
                        report_queue.push_back(make_record(k, st_min[k], st_max[k],
                            st_sum[k] / longint'(st_cnt[k]), st_cnt[k], id, 1'b0));
                end
                v = area_total > 64'h7FFF_FFFF_FFFF ? 64'sh7FFF_FFFF_FFFF : area_total;
                report_queue.push_back(make_record(REC_TALLY, v, v, v, n_boundary,
                    n_internal > 24'hFF_FFFF ? 24'hFF_FFFF : n_internal, 1'b1));
                clear_stats();
            end
            default: ;
        endcase
    endfunction

    function automatic t_item blank_item(logic [1:0] mode);
        t_item it;
        it.mode = mode; it.bnd = 1'b0;
        it.ox = 0; it.oy = 0; it.nx = 0; it.ny = 0; it.ax = 0; it.ay = 0;
        it.len = 0; it.a1 = 0; it.a2 = 0; it.q = 0;
        return it;
    endfunction

    function automatic t_item face_item(bit bnd, int ox, int oy, int nx, int ny,
                                        int ax, int ay, int unsigned len,
                                        int unsigned a1, int unsigned a2);
        t_item it;
        it = blank_item(MODE_FACE);
        it.bnd = bnd; it.ox = ox; it.oy = oy; it.nx = nx; it.ny = ny;
        it.ax = ax; it.ay = ay; it.len = len; it.a1 = a1; it.a2 = a2;
        return it;
    endfunction

    function automatic t_item cell_item(int unsigned a, int q);
        t_item it;
        it = blank_item(MODE_CELL);
        it.a1 = a; it.q = q;
        return it;
    endfunction

    // Random content with every field bit exercised. Coordinates are mostly
    // small so that geometry is plausible; now and then full-range values.
    function automatic t_item random_item();
        t_item it;
        int sel;
        sel = $urandom_range(0, 99);
        it.mode = sel < 55 ? MODE_FACE : sel < 92 ? MODE_CELL : sel < 97 ? MODE_REPORT : 2'd3;
        it.bnd = $urandom_range(0, 3) == 0;
        if ($urandom_range(0, 4) == 0) begin
            it.ox = $urandom; it.oy = $urandom; it.nx = $urandom; it.ny = $urandom;
            it.ax = $urandom; it.ay = $urandom;
        end else begin
            it.ox = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            it.oy = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            it.nx = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            it.ny = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            it.ax = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            it.ay = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        end
        it.len = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000);
        it.a1 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
        it.a2 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
        it.q = $urandom;
        return it;
    endfunction

    // Directed rows. Where the row's records can be read off directly, the
    // expected record is typed into the table; the predictor is still run so
    // its state stays in step, and the typed rows are checked against it.
    t_item   directed_items[N_DIRECTED];
    t_record typed_record[N_DIRECTED];
    bit      has_typed[N_DIRECTED];

    initial begin
        for (int i = 0; i < N_DIRECTED; i++) has_typed[i] = 1'b0;
        // Report from an empty state: all zeros, last record flagged.
        directed_items[0] = blank_item(MODE_REPORT);
        has_typed[0] = 1'b1;
        typed_record[0] = make_record(REC_TALLY, 0, 0, 0, 0, 0, 1'b1);
        // Boundary face with maximal length.
        directed_items[1] = face_item(1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
        // Coincident centres give a zero denominator, so the angle is zero.
        directed_items[2] = face_item(0, 100, 100, 100, 100, 65536, 0, 65536, 65536, 65536);
        // Aligned face: zero angle.
        directed_items[3] = face_item(0, 0, 0, 65536, 0, 65536, 0, 65536, 65536, 262144);
        // Opposed normal: 180 degrees.
        directed_items[4] = face_item(0, 0, 0, 65536, 0, -65536, 0, 65536, 65536, 65536);
        // Perpendicular normal: 90 degrees.
        directed_items[5] = face_item(0, 0, 0, 0, 65536, 65536, 0, 65536, 65536, 65536);
        // Extreme centres force halving of the displacement; a zero area
        // saturates the ratio.
        directed_items[6] = face_item(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                      32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        // Zero length with separated centres: zero denominator again.
        directed_items[7] = face_item(0, 0, 0, 65536, 65536, 65536, 65536, 0, 32'hFFFF_FFFF, 1);
        // Tied angle keeps the first face.
        directed_items[8] = face_item(0, 0, 0, -65536, 0, 65536, 0, 65536, 1, 1);
        directed_items[9] = cell_item(0, 32'sh7FFF_FFFF);
        directed_items[10] = cell_item(32'hFFFF_FFFF, 32'sh8000_0000);
        // A tied worst quality keeps the first cell.
        directed_items[11] = cell_item(65536, 32'sh8000_0000);
        directed_items[12] = cell_item(1, 0);
        // Unused mode is ignored.
        directed_items[13] = blank_item(2'd3);
        directed_items[13].bnd = 1'b1;
        directed_items[14] = blank_item(MODE_REPORT);
        // After a report all is clear again.
        directed_items[15] = blank_item(MODE_REPORT);
        has_typed[15] = 1'b1;
        typed_record[15] = make_record(REC_TALLY, 0, 0, 0, 0, 0, 1'b1);
        // Five maximal-area cells: the total stays below the 2^47 saturation.
        for (int i = 16; i < 21; i++) directed_items[i] = cell_item(32'hFFFF_FFFF, i);
        directed_items[21] = blank_item(MODE_REPORT);
    end

    task automatic send_item(t_item it);
        i_mode <= it.mode; i_is_boundary <= it.bnd;
        i_owner_x <= it.ox; i_owner_y <= it.oy;
        i_neighbour_x <= it.nx; i_neighbour_y <= it.ny;
        i_normal_x <= it.ax; i_normal_y <= it.ay;
        i_edge_length <= it.len; i_first_area <= it.a1; i_second_area <= it.a2;
        i_quality <= it.q;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        predict_item(it);
        @(negedge i_clk);
    endtask

    // Sender: bursts of random length with gaps; valid is lowered only
    // inside a gap, so it never drops and rises in the same step.
    task automatic send_with_gaps(t_item it, ref int burst_left);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        send_item(it);
    endtask

    initial begin
        int burst_left;
        t_item it;
        int n_typed_checked;
        clear_stats();
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_with_gaps(directed_items[i], burst_left);
            if (has_typed[i] && report_queue.size() > 0
                && report_queue[$] !== typed_record[i]) begin
                n_errors++;
                $display("directed row %0d: predictor disagrees with typed record", i);
            end
        end
        // Long receiver hold-off while the sender keeps offering items: a
        // report fills the output register and the input then stalls.
        hold_off = 1'b1;
        send_item(blank_item(MODE_REPORT));
        for (int i = 0; i < 4; i++) send_item(cell_item($urandom, $urandom));
        hold_off = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            it = random_item();
            if (i % 30 == 0 && i > 0) it.mode = MODE_REPORT;
            send_with_gaps(it, burst_left);
        end
        send_with_gaps(blank_item(MODE_REPORT), burst_left);
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: a stall pattern of its own, with quiet stretches, plus the
    // long hold-off counted here.
    initial begin
        int phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (1500) @(negedge i_clk);
                while (hold_off) begin
                    i_ready <= 1'b1;
                    @(negedge i_clk);
                end
            end
            phase++;
            if ((phase / 64) % 3 == 0)
                i_ready <= 1'b1;
            else
                i_ready <= (phase % 7 < 4) && ($urandom_range(0, 3) != 0);
        end
    end

    // Output checker.
    always @(posedge i_clk) begin
        t_record got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = make_record(0, 0, 0, 0, 0, 0, 0);
            got.rec = o_record; got.mn = o_minimum; got.mx = o_maximum;
            got.mean = o_mean; got.cnt = o_value_count; got.id = o_extreme_id;
            got.last = o_last;
            if (report_queue.size() == 0) begin
                n_errors++;
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected record %p", got);
            end else begin
                want = report_queue.pop_front();
                if (got !== want) begin
                    n_errors++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("record mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[mesh_quality_statistics_unit] ERROR");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (report_queue.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (n_errors == 0)
            $display("[mesh_quality_statistics_unit] OK");
        else
            $display("[mesh_quality_statistics_unit] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
